@@ rtl/block_crc_encoder_checker_macros.svh @@
// Assertion macros for the checker file of the block CRC unit.
`ifndef BLOCK_CRC_ENCODER_CHECKER_MACROS_SVH
`define BLOCK_CRC_ENCODER_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bcrc_pkg.sv @@
// Shared types and constants of the block CRC encoder and checker.
package bcrc_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_CRC_WIDTH_SEL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE   = 2'd3;

	localparam logic [1:0]  RST_CRC_WIDTH_SEL = 2'd0;
	localparam logic [23:0] RST_CRC_POLY      = 24'd7;
	localparam logic [12:0] RST_BLOCK_BITS    = 13'd64;
	localparam logic        RST_DECODE_MODE   = 1'b0;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_CRC     = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// One result word
	typedef struct packed {
		logic [1:0] out_kind;
		logic       out_bit;
		logic       block_ok;
		logic       short_block;
		logic       run_last;
	} result_t;

	// What one input word causes
	typedef struct packed {
		logic emit_payload;
		logic payload_bit;
		logic emit_crc;
		logic emit_stat;
		logic stat_ok;
		logic stat_short;
		logic clear;
	} step_flags_t;

endpackage

@@ rtl/bcrc_in_if.sv @@
// Input channel: one stream bit per word.
interface bcrc_in_if;
	logic valid;
	logic ready;
	logic in_bit;
	logic stream_end;

	modport source (output valid, output in_bit, output stream_end, input ready);
	modport sink (input valid, input in_bit, input stream_end, output ready);
endinterface

@@ rtl/bcrc_out_if.sv @@
// Output channel: one payload bit, CRC bit or block status per word.
interface bcrc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic       out_bit;
	logic       block_ok;
	logic       short_block;
	logic       run_last;

	modport source (output valid, output out_kind, output out_bit, output block_ok,
		output short_block, output run_last, input ready);
	modport sink (input valid, input out_kind, input out_bit, input block_ok,
		input short_block, input run_last, output ready);
endinterface

@@ rtl/bcrc_step.sv @@
// One division step of the CRC unit: next state and the results of one bit.
module bcrc_step #(
	parameter int CW        = 24,
	parameter int MAX_BLOCK = 4096,
	parameter int CNTW      = 13,
	parameter int WCW       = 5,
	parameter int IDXW      = 5
) (
	input  logic [1:0]            width_sel,
	input  logic [23:0]           poly,
	input  logic [12:0]           block_bits,
	input  logic                  decode,
	input  logic                  in_bit,
	input  logic                  stream_end,
	input  logic [CW-1:0]         rem,
	input  logic [CW-1:0]         tail,
	input  logic [CNTW-1:0]       cnt,
	output logic [CW-1:0]         rem_upd,
	output logic [CW-1:0]         tail_nx,
	output logic [CNTW-1:0]       cnt_nx,
	output logic [WCW-1:0]        w,
	output bcrc_pkg::step_flags_t flags
);

	localparam logic [CNTW-1:0] CAP = CNTW'(MAX_BLOCK + CW);

	logic [5:0]      w_sel;
	logic [IDXW-1:0] top_idx;
	logic [CW-1:0]   mask;
	logic [CW-1:0]   poly_m;
	logic [CW-1:0]   sh;
	logic [CW+23:0]  poly_ext;
	logic [CNTW-1:0] bb;
	logic [CNTW-1:0] w_c;
	logic [CNTW-1:0] cnt_inc;
	logic            carry;

	// Resolve the CRC width, limited to the register size
	assign w_sel   = (width_sel == 2'd0) ? 6'd8 : (width_sel == 2'd1) ? 6'd16 : 6'd24;
	assign w       = (32'(w_sel) > CW) ? WCW'(CW) : WCW'(w_sel);
	assign top_idx = IDXW'(w - WCW'(1));
	assign mask    = {CW{1'b1}} >> (WCW'(CW) - w);
	assign poly_ext = {{CW{1'b0}}, poly};
	assign poly_m  = poly_ext[CW-1:0] & mask;
	assign carry   = rem[top_idx];
	assign sh      = rem << 1;
	assign w_c     = CNTW'(w);
	assign cnt_inc = (cnt == CAP) ? cnt : cnt + CNTW'(1);

	// Clamp the block size to one and to the largest block
	always_comb begin
		if (block_bits == 13'd0) begin
			bb = CNTW'(1);
		end else if (32'(block_bits) > MAX_BLOCK) begin
			bb = CNTW'(MAX_BLOCK);
		end else begin
			bb = CNTW'(block_bits);
		end
	end

	// Advance the division and decide what the bit emits
	always_comb begin
		flags   = '0;
		rem_upd = rem;
		tail_nx = tail;
		cnt_nx  = cnt_inc;
		if (!decode) begin
			rem_upd = (sh & mask) ^ ((carry ^ in_bit) ? poly_m : '0);
			flags.emit_payload = 1'b1;
			flags.payload_bit  = in_bit;
			if (cnt_inc >= bb || stream_end) begin
				flags.emit_crc = 1'b1;
				flags.clear    = 1'b1;
			end
		end else begin
			if (cnt >= w_c) begin
				flags.emit_payload = 1'b1;
				flags.payload_bit  = tail[top_idx];
			end
			tail_nx = (sh & '0) | (((tail << 1) | CW'(in_bit)) & mask);
			rem_upd = ((sh | CW'(in_bit)) & mask) ^ (carry ? poly_m : '0);
			if (stream_end) begin
				flags.emit_stat  = 1'b1;
				flags.stat_short = (cnt_inc <= w_c);
				flags.stat_ok    = !(cnt_inc <= w_c) && (rem_upd == '0);
				flags.clear      = 1'b1;
			end else if (cnt_inc >= bb + w_c) begin
				flags.emit_stat = 1'b1;
				flags.stat_ok   = (rem_upd == '0);
				flags.clear     = 1'b1;
			end
		end
	end

endmodule

@@ rtl/block_crc_encoder_checker.sv @@
// Top level of the bit-serial block CRC encoder and checker.
//
//   port    | dir | fields                                           | handshake
//   --------+-----+--------------------------------------------------+-----------
//   din     | in  | in_bit, stream_end                               | valid/ready
//   dout    | out | out_kind, out_bit, block_ok, short_block, run_last | valid/ready
//   cfg     | in  | cfg_index, cfg_data                              | cfg_we
//
// One input word is taken per cycle unless the output stalls or results are pending;
// its first result goes from the input register to the output register. An encode
// block end adds W CRC bits out of the CRC shift register, a decode block end after
// a payload bit adds one status word; input stalls while those drain. Reset clears
// the division state and loads the register defaults. A stalled output holds its
// word in the output register while the input register takes one more word.
module block_crc_encoder_checker #(
	parameter int MAX_BLOCK_BITS = 4096,
	parameter int MAX_CRC_WIDTH  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bcrc_in_if.sink                          din,
	bcrc_out_if.source                       dout,
	input  logic                             cfg_we,
	input  logic [bcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bcrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW   = MAX_CRC_WIDTH;
	localparam int CNTW = $clog2(MAX_BLOCK_BITS + MAX_CRC_WIDTH + 1);
	localparam int WCW  = $clog2(CW + 1);
	localparam int IDXW = $clog2(CW);

	// Configuration registers
	logic [1:0]  width_sel_q;
	logic [23:0] poly_q;
	logic [12:0] block_bits_q;
	logic        decode_q;

	// Input register
	logic valid_s1;
	logic bit_s1;
	logic end_s1;

	// Division state
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   tail_q;
	logic [CNTW-1:0] cnt_q;

	// Pending results of the word in progress
	logic [CW-1:0]  crc_sr_q;
	logic [WCW-1:0] crc_left_q;
	logic           stat_pend_q;
	logic           stat_ok_q;
	logic           stat_short_q;

	// Output register
	logic              out_valid_q;
	bcrc_pkg::result_t out_q;

	// Step results
	logic [CW-1:0]         rem_upd;
	logic [CW-1:0]         tail_nx;
	logic [CNTW-1:0]       cnt_nx;
	logic [WCW-1:0]        w;
	bcrc_pkg::step_flags_t flags;

	logic pending;
	logic load_ok;
	logic zero_res;
	logic consume;

	bcrc_step #(
		.CW        (CW),
		.MAX_BLOCK (MAX_BLOCK_BITS),
		.CNTW      (CNTW),
		.WCW       (WCW),
		.IDXW      (IDXW)
	) u_step (
		.width_sel  (width_sel_q),
		.poly       (poly_q),
		.block_bits (block_bits_q),
		.decode     (decode_q),
		.in_bit     (bit_s1),
		.stream_end (end_s1),
		.rem        (rem_q),
		.tail       (tail_q),
		.cnt        (cnt_q),
		.rem_upd    (rem_upd),
		.tail_nx    (tail_nx),
		.cnt_nx     (cnt_nx),
		.w          (w),
		.flags      (flags)
	);

	// Handshake control
	assign pending  = (crc_left_q != '0) || stat_pend_q;
	assign load_ok  = !out_valid_q || dout.ready;
	assign zero_res = !flags.emit_payload && !flags.emit_stat;
	assign consume  = valid_s1 && !pending && (load_ok || zero_res);

	assign din.ready = !valid_s1 || consume;

	assign dout.valid       = out_valid_q;
	assign dout.out_kind    = out_q.out_kind;
	assign dout.out_bit     = out_q.out_bit;
	assign dout.block_ok    = out_q.block_ok;
	assign dout.short_block = out_q.short_block;
	assign dout.run_last    = out_q.run_last;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_sel_q  <= bcrc_pkg::RST_CRC_WIDTH_SEL;
			poly_q       <= bcrc_pkg::RST_CRC_POLY;
			block_bits_q <= bcrc_pkg::RST_BLOCK_BITS;
			decode_q     <= bcrc_pkg::RST_DECODE_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcrc_pkg::REG_CRC_WIDTH_SEL: width_sel_q  <= cfg_data[1:0];
				bcrc_pkg::REG_CRC_POLY:      poly_q       <= cfg_data[23:0];
				bcrc_pkg::REG_BLOCK_BITS:    block_bits_q <= cfg_data[12:0];
				bcrc_pkg::REG_DECODE_MODE:   decode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hold one input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			bit_s1   <= 1'b0;
			end_s1   <= 1'b0;
		end else if (din.valid && din.ready) begin
			valid_s1 <= 1'b1;
			bit_s1   <= din.in_bit;
			end_s1   <= din.stream_end;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Advance the division state, clear it at a block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (consume) begin
			if (flags.clear) begin
				rem_q  <= '0;
				tail_q <= '0;
				cnt_q  <= '0;
			end else begin
				rem_q  <= rem_upd;
				tail_q <= tail_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	// Load the output register: pending CRC bits, then status, then a new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			crc_sr_q     <= '0;
			crc_left_q   <= '0;
			stat_pend_q  <= 1'b0;
			stat_ok_q    <= 1'b0;
			stat_short_q <= 1'b0;
		end else if (load_ok) begin
			if (crc_left_q != '0) begin
				out_valid_q <= 1'b1;
				out_q       <= '{bcrc_pkg::KIND_CRC, crc_sr_q[CW-1], 1'b0, 1'b0,
					crc_left_q == WCW'(1)};
				crc_sr_q    <= crc_sr_q << 1;
				crc_left_q  <= crc_left_q - WCW'(1);
			end else if (stat_pend_q) begin
				out_valid_q <= 1'b1;
				out_q       <= '{bcrc_pkg::KIND_STATUS, 1'b0, stat_ok_q, stat_short_q, 1'b1};
				stat_pend_q <= 1'b0;
			end else if (consume && !zero_res) begin
				out_valid_q <= 1'b1;
				if (flags.emit_payload) begin
					out_q <= '{bcrc_pkg::KIND_PAYLOAD, flags.payload_bit, 1'b0, 1'b0,
						!(flags.emit_crc || flags.emit_stat)};
					if (flags.emit_crc) begin
						crc_sr_q   <= rem_upd << (WCW'(CW) - w);
						crc_left_q <= w;
					end
					stat_pend_q  <= flags.emit_stat;
					stat_ok_q    <= flags.stat_ok;
					stat_short_q <= flags.stat_short;
				end else begin
					out_q <= '{bcrc_pkg::KIND_STATUS, 1'b0, flags.stat_ok, flags.stat_short,
						1'b1};
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/bcrc_checker.sv @@
// Port-level assertions for the block CRC unit and their binding.
`include "block_crc_encoder_checker_macros.svh"

module bcrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic       out_bit,
	input logic       block_ok,
	input logic       short_block,
	input logic       run_last
);

	// A stalled output word keeps its kind, bit and run_last
	`BCRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_bit) && $stable(run_last), "output word changed while stalled")

	// A status always closes the run of its input word
	`BCRC_ASSERT_SAME(a_status_last, out_valid && out_kind == bcrc_pkg::KIND_STATUS, run_last, "status without run_last")

	// CRC bits of one block leave back to back
	`BCRC_ASSERT_NEXT(a_crc_burst, out_valid && out_ready && out_kind == bcrc_pkg::KIND_CRC && !run_last, out_valid && out_kind == bcrc_pkg::KIND_CRC, "CRC burst broken")

	// Only a status carries status flags
	`BCRC_ASSERT_SAME(a_flags_status, out_valid && out_kind != bcrc_pkg::KIND_STATUS, !block_ok && !short_block, "status flags on a bit word")

endmodule

bind block_crc_encoder_checker bcrc_checker u_bcrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_kind    (dout.out_kind),
	.out_bit     (dout.out_bit),
	.block_ok    (dout.block_ok),
	.short_block (dout.short_block),
	.run_last    (dout.run_last)
);
